### sv/sodt_pkg.sv
// ----------------------------------------------------------------------------
// sodt_pkg: shared types and constants for the slot occupancy debounce timer
// Field widths, register codes, lane result struct and pipeline control struct.
// ----------------------------------------------------------------------------
package sodt_pkg;

    localparam int unsigned DETECT_W = 4;   // detection bits carried per item
    localparam int unsigned TIME_W   = 32;  // seconds timestamp
    localparam int unsigned CNT_W    = 4;   // debounce counter / threshold
    localparam int unsigned MIN_W    = 27;  // parked minutes per slot
    localparam int unsigned FREE_W   = 3;   // free slot count field
    localparam int unsigned OUT_SLOTS = 4;  // minutes fields in a result

    localparam logic [CNT_W-1:0] COUNT_MAX     = 4'hF;
    localparam logic [CNT_W-1:0] STABLE_RESET  = 4'd3;
    localparam logic [MIN_W-1:0] MINUTES_MAX   = 27'd71582788;

    // x / 60 == (x * RECIP_60) >> RECIP_SHIFT, exact for every 32-bit x
    localparam logic [TIME_W-1:0] RECIP_60    = 32'h8888_8889;
    localparam int unsigned       RECIP_SHIFT = 37;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_STABLE_SAMPLES = 1'b0,
        CFG_CLOCK_PRESENT  = 1'b1
    } t_cfg_reg;

    // What the minutes stage does with a slot's parked minutes
    typedef enum logic [1:0] {
        ACT_HOLD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_LOAD  = 2'd2
    } t_min_act;

    // Pipeline control shared by all lanes and the merge stage
    typedef struct packed {
        logic take;  // input transaction accepted this cycle
        logic adv;   // pipeline advances this cycle
        logic v2;    // stage 2 holds a valid item
    } t_pipe_ctl;

    // Stage 1 result of one slot lane
    typedef struct packed {
        logic              occ;
        logic              flip;
        t_min_act          act;
        logic [TIME_W-1:0] diff;
    } t_lane_out;

endpackage

### sv/sodt_lane.sv
// ----------------------------------------------------------------------------
// sodt_lane: per-slot debounce and entry timestamp
// Holds one slot's occupancy, debounce counter and entry time; registers the
// elapsed-time operand and the minutes action for the divide stage.
// ----------------------------------------------------------------------------
module sodt_lane
    import sodt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  logic              i_seen,
    input  logic [TIME_W-1:0] i_now,
    input  logic [CNT_W-1:0]  i_stable,
    input  logic              i_clk_present,
    output t_lane_out         o_lane
);

    logic              r_occ;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_entry;
    logic              r_flip;
    t_min_act          r_act;
    logic [TIME_W-1:0] r_diff;

    logic              differ;
    logic              flip;
    logic [CNT_W-1:0]  cnt_inc;
    logic              n_occ;
    logic [CNT_W-1:0]  n_cnt;
    logic [TIME_W-1:0] n_entry;
    t_min_act          n_act;

    always_comb begin
        differ  = (i_seen != r_occ);
        cnt_inc = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
        flip    = differ && (cnt_inc >= i_stable);
        n_occ   = flip ? i_seen : r_occ;
        n_cnt   = (differ && !flip) ? cnt_inc : '0;
        n_entry = (flip && i_seen && i_clk_present) ? i_now : r_entry;
        if (n_occ && i_clk_present && (i_now > n_entry)) begin
            n_act = ACT_LOAD;
        end else if (flip && !(i_seen && i_clk_present)) begin
            n_act = ACT_CLEAR;
        end else begin
            n_act = ACT_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 1'b0;
            r_cnt   <= '0;
            r_entry <= '0;
            r_flip  <= 1'b0;
            r_act   <= ACT_HOLD;
        end else if (i_ctl.take) begin
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            r_entry <= n_entry;
            r_flip  <= flip;
            r_act   <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_diff <= i_now - n_entry;
        end
    end

    assign o_lane = '{occ: r_occ, flip: r_flip, act: r_act, diff: r_diff};

    // a flip always restarts the debounce count
    a_flip_clears_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.take |=> (!r_flip || (r_cnt == '0)))
        else $error("slot flipped without clearing its counter");

endmodule

### sv/sodt_min.sv
// ----------------------------------------------------------------------------
// sodt_min: parked minutes for one slot
// Divides elapsed seconds by 60 through a reciprocal multiply (stage 2) and
// applies the hold/clear/load action to the minutes register (stage 3).
// ----------------------------------------------------------------------------
module sodt_min
    import sodt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  t_min_act          i_act,
    input  logic [TIME_W-1:0] i_diff,
    output logic [MIN_W-1:0]  o_minutes
);

    logic [2*TIME_W-1:0] prod;
    logic [MIN_W-1:0]    r_quot;
    t_min_act            r_act;
    logic [MIN_W-1:0]    r_minutes;

    assign prod = {{TIME_W{1'b0}}, i_diff} * {{TIME_W{1'b0}}, RECIP_60};

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_quot <= prod[RECIP_SHIFT +: MIN_W];
            r_act  <= i_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minutes <= '0;
        end else if (i_ctl.adv && i_ctl.v2) begin
            case (r_act)
                ACT_CLEAR: r_minutes <= '0;
                ACT_LOAD:  r_minutes <= r_quot;
                default:   r_minutes <= r_minutes;
            endcase
        end
    end

    assign o_minutes = r_minutes;

    a_minutes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_minutes <= MINUTES_MAX)
        else $error("parked minutes beyond 32-bit seconds range");

endmodule

### sv/sodt_merge.sv
// ----------------------------------------------------------------------------
// sodt_merge: combines the lanes into mask, change flag and free count
// Reduces the stage 1 lane results and carries them through stages 2 and 3
// in step with the minutes pipeline.
// ----------------------------------------------------------------------------
module sodt_merge
    import sodt_pkg::*;
#(
    parameter int unsigned SLOTS = 4
) (
    input  logic                 i_clk,
    input  t_pipe_ctl            i_ctl,
    input  logic [SLOTS-1:0]     i_occ,
    input  logic [SLOTS-1:0]     i_flip,
    output logic [DETECT_W-1:0]  o_mask,
    output logic                 o_changed,
    output logic [FREE_W-1:0]    o_free
);

    localparam int unsigned SUM_W = $clog2(SLOTS + 1);

    logic [DETECT_W-1:0] mask;
    logic [SUM_W-1:0]    free_sum;
    logic [DETECT_W-1:0] r_mask2, r_mask3;
    logic                r_chg2, r_chg3;
    logic [FREE_W-1:0]   r_free2, r_free3;
    logic [FREE_W+SUM_W-1:0] free_ext;

    always_comb begin
        mask     = '0;
        free_sum = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (k < DETECT_W) begin
                mask[k] = i_occ[k];
            end
            free_sum = free_sum + SUM_W'(!i_occ[k]);
        end
        free_ext = {{FREE_W{1'b0}}, free_sum};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_mask2 <= mask;
            r_chg2  <= |i_flip;
            r_free2 <= free_ext[FREE_W-1:0];
            r_mask3 <= r_mask2;
            r_chg3  <= r_chg2;
            r_free3 <= r_free2;
        end
    end

    assign o_mask    = r_mask3;
    assign o_changed = r_chg3;
    assign o_free    = r_free3;

endmodule

### sv/slot_occupancy_debounce_timer.sv
// ----------------------------------------------------------------------------
// slot_occupancy_debounce_timer: multi-slot occupancy debounce and parking timer
// Top level: stream ports, configuration registers, valid pipeline, lanes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries one sensor tick per transaction: the
//   detection bits of slots 0..3 and the current time in seconds. Master
//   stream (o_m_*) returns exactly one result per tick: debounced occupancy
//   mask, changed flag, free slot count and parked minutes of slots 0..3.
//   Pipeline: each input transaction passes the stage 1 debounce lanes, the
//   stage 2 reciprocal multiply by 1/60 and the stage 3 minutes registers.
//   Throughput: one tick per cycle unless the result stalls; the debounce state
//   of each slot updates in the accept cycle, so back-to-back ticks need no stall.
//   Stall: when the result register is full and i_m_tready is low, the whole
//   pipeline freezes and o_s_tready drops; it never drops otherwise.
//   Reset (synchronous, i_rst_n low): all slots free, counters and entry
//   times zero, minutes zero, stable_samples = 3, clock_present = 0, and the
//   pipeline empty. Configuration writes (i_cfg_*) take effect at once; the user
//   makes them only while no tick is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module slot_occupancy_debounce_timer
    import sodt_pkg::*;
#(
    parameter int unsigned SLOTS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_addr,
    input  logic [3:0]    i_cfg_wdata,
    // tick input
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [39:0]   i_s_tdata,   // detect_bits[3:0], now_seconds[35:4], zero pad
    // result output
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [119:0]  o_m_tdata    // occupied_mask[3:0], any_changed[4],
                                       // free_count[7:5], minutes_slot0[34:8],
                                       // minutes_slot1[61:35], minutes_slot2[88:62],
                                       // minutes_slot3[115:89], zero pad
);

    // configuration registers
    logic [CNT_W-1:0] r_stable;
    logic             r_clk_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= STABLE_RESET;
            r_clk_present <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_STABLE_SAMPLES: r_stable      <= i_cfg_wdata[CNT_W-1:0];
                CFG_CLOCK_PRESENT:  r_clk_present <= i_cfg_wdata[0];
                default:            r_stable      <= r_stable;
            endcase
        end
    end

    // input field unpack
    logic [DETECT_W-1:0] detect_bits;
    logic [TIME_W-1:0]   now_seconds;
    assign detect_bits = i_s_tdata[DETECT_W-1:0];
    assign now_seconds = i_s_tdata[DETECT_W +: TIME_W];

    // valid pipeline: all three stages move together
    logic      r_v1, r_v2, r_v3;
    logic      adv;
    t_pipe_ctl ctl;

    assign adv        = !r_v3 || i_m_tready;
    assign o_s_tready = adv;
    assign ctl        = '{take: i_s_tvalid && adv, adv: adv, v2: r_v2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_m_tvalid = r_v3;

    // one lane per slot; slots past the detection field always see free
    t_lane_out        lane [SLOTS];
    logic [SLOTS-1:0] lane_occ;
    logic [SLOTS-1:0] lane_flip;
    logic [MIN_W-1:0] minutes [SLOTS];

    for (genvar g = 0; g < SLOTS; g++) begin : g_lane
        logic seen;
        if (g < DETECT_W) begin : g_det
            assign seen = detect_bits[g];
        end else begin : g_nodet
            assign seen = 1'b0;
        end

        sodt_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_seen        (seen),
            .i_now         (now_seconds),
            .i_stable      (r_stable),
            .i_clk_present (r_clk_present),
            .o_lane        (lane[g])
        );

        sodt_min u_min (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_act     (lane[g].act),
            .i_diff    (lane[g].diff),
            .o_minutes (minutes[g])
        );

        assign lane_occ[g]  = lane[g].occ;
        assign lane_flip[g] = lane[g].flip;
    end

    // merge stage
    logic [DETECT_W-1:0] occupied_mask;
    logic                any_changed;
    logic [FREE_W-1:0]   free_count;

    sodt_merge #(.SLOTS(SLOTS)) u_merge (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_occ     (lane_occ),
        .i_flip    (lane_flip),
        .o_mask    (occupied_mask),
        .o_changed (any_changed),
        .o_free    (free_count)
    );

    // result pack; minutes fields for slots that do not exist read zero
    logic [OUT_SLOTS*MIN_W-1:0] minutes_flat;
    for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_out
        if (k < SLOTS) begin : g_used
            assign minutes_flat[k*MIN_W +: MIN_W] = minutes[k];
        end else begin : g_unused
            assign minutes_flat[k*MIN_W +: MIN_W] = '0;
        end
    end

    assign o_m_tdata = {4'b0, minutes_flat, free_count, any_changed, occupied_mask};

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // an empty result register never back-pressures the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // a stalled result freezes the stages behind it
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_m_tready) |=> (r_v3 && $stable(r_v2) && $stable(r_v1)))
        else $error("pipeline moved during output stall");

endmodule
